// ===== rtl/bcu_pkg.sv =====
`timescale 1ns / 1ps

package bcu_pkg;

  // Width of the numerator product, the denominator and the quotient.
  localparam int RESULT_WIDTH = 64;

  // Width of the n and k fields.
  localparam int COUNT_W = 7;

  // Width of m, which is at most half of the largest n.
  localparam int HALF_W = COUNT_W - 1;

  // Width of one product of the shared multiplier.
  localparam int PROD_W = RESULT_WIDTH + COUNT_W;

  // Width of the bit counter of the divider.
  localparam int DIV_CNT_W = $clog2(RESULT_WIDTH + 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_RANGE    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

endpackage

// ===== rtl/bcu_div.sv =====
`timescale 1ns / 1ps

module bcu_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [bcu_pkg::RESULT_WIDTH-1:0]  dividend,
  input  logic [bcu_pkg::RESULT_WIDTH-1:0]  divisor,
  output logic                              done,
  output logic [bcu_pkg::RESULT_WIDTH-1:0]  quotient
);

  localparam int RW = bcu_pkg::RESULT_WIDTH;
  localparam int CW = bcu_pkg::DIV_CNT_W;

  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [RW:0]   rem_sh;
  logic          ge;

  // Restoring division, one quotient bit per cycle, most significant first.
  // The remainder stays below the divisor, so it always fits in RW bits.
  always_comb begin
    rem_sh   = {rem_r, quo_r[RW-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? RW'(rem_sh - {1'b0, dvs_r}) : rem_sh[RW-1:0];
      quo_nxt = {quo_r[RW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/binomial_coefficient_unit_top.sv =====
`timescale 1ns / 1ps

// Binomial coefficient unit: returns C(n,k) for each request word.
// Input channel: in_tdata carries n in bits [6:0] and k in bits [13:7].
// Result channel: out_tdata carries the coefficient, out_tuser the status
// (0 ok, 1 k greater than n, 2 numerator overflow); the coefficient is zero
// unless the status is ok.
// One request is worked on at a time and in_tready is low while it runs.
// With m the smaller of k and n-k, one shared multiplier forms the
// numerator and then m factorial, a bit-serial divider forms the
// quotient, and the result register is loaded; the result word then goes
// to the output register and the block returns to idle for the next word.
// A request with k greater than n, or one whose numerator overflows,
// finishes early.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver stalls and the next result is ready too, the
// block holds that result and takes no new word until the register frees.
// Reset (rst_n low, synchronous) drops any request in flight and any
// waiting result.
module binomial_coefficient_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] total_count, [13:7] chosen_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] coefficient
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int RW = bcu_pkg::RESULT_WIDTH;
  localparam int NW = bcu_pkg::COUNT_W;
  localparam int HW = bcu_pkg::HALF_W;
  localparam int PW = bcu_pkg::PROD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NUM,
    ST_DEN,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] num_r, num_nxt;
  logic [RW-1:0] den_r, den_nxt;
  logic [NW-1:0] fac_r, fac_nxt;
  logic [HW-1:0] cnt_r, cnt_nxt;
  logic [HW-1:0] m_r, m_nxt;
  logic [RW-1:0] res_r, res_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [63:0]   out_tdata_r, out_tdata_nxt;
  logic [1:0]    out_tuser_r, out_tuser_nxt;

  logic [NW-1:0] n_in, k_in, nk_in;
  logic [RW-1:0] mul_a;
  logic [PW-1:0] mul_prod;
  logic          mul_ovf;
  logic          div_start, div_done;
  logic [RW-1:0] div_quo;

  assign n_in  = in_tdata[6:0];
  assign k_in  = in_tdata[13:7];
  assign nk_in = n_in - k_in;

  // The single multiplier serves both the numerator and the factorial.
  assign mul_a    = (state_r == ST_NUM) ? num_r : den_r;
  assign mul_prod = PW'(mul_a) * PW'(fac_r);
  assign mul_ovf  = |mul_prod[PW-1:RW];

  assign div_start = (state_r == ST_DEN) && (cnt_r == '0);

  bcu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    fac_nxt        = fac_r;
    cnt_nxt        = cnt_r;
    m_nxt          = m_r;
    res_nxt        = res_r;
    stat_nxt       = stat_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          num_nxt = RW'(1);
          den_nxt = RW'(1);
          if (k_in > n_in) begin
            res_nxt   = '0;
            stat_nxt  = bcu_pkg::STATUS_RANGE;
            state_nxt = ST_DONE;
          end else begin
            m_nxt     = HW'((k_in < nk_in) ? k_in : nk_in);
            cnt_nxt   = m_nxt;
            // First numerator factor is n - m + 1.
            fac_nxt   = n_in - NW'(m_nxt) + NW'(1);
            state_nxt = ST_NUM;
          end
        end
      end
      ST_NUM: begin
        if (cnt_r == '0) begin
          fac_nxt   = NW'(1);
          cnt_nxt   = m_r;
          state_nxt = ST_DEN;
        end else if (mul_ovf) begin
          res_nxt   = '0;
          stat_nxt  = bcu_pkg::STATUS_OVERFLOW;
          state_nxt = ST_DONE;
        end else begin
          num_nxt = mul_prod[RW-1:0];
          fac_nxt = fac_r + NW'(1);
          cnt_nxt = cnt_r - HW'(1);
        end
      end
      ST_DEN: begin
        // m! never exceeds the numerator, so the truncation loses nothing.
        if (cnt_r == '0) begin
          state_nxt = ST_DIV;
        end else begin
          den_nxt = mul_prod[RW-1:0];
          fac_nxt = fac_r + NW'(1);
          cnt_nxt = cnt_r - HW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt   = div_quo;
          stat_nxt  = bcu_pkg::STATUS_OK;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = 64'(res_r);
          out_tuser_nxt  = stat_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cnt_r        <= cnt_nxt;
    end
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    fac_r       <= fac_nxt;
    m_r         <= m_nxt;
    res_r       <= res_nxt;
    stat_r      <= stat_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== tb/sv/binomial_coefficient_unit_top_test.sv =====
`timescale 1ns / 1ps

module binomial_coefficient_unit_top_test;

  localparam int RESET_CYCLES = 12;
  localparam int PHASE_WORDS = 576;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT = 1_500_000;

  // The padding bits above chosen stay zero.
  typedef struct packed {
    logic [1:0]                  pad;
    logic [bcu_pkg::COUNT_W-1:0] chosen;
    logic [bcu_pkg::COUNT_W-1:0] total;
  } request_t;

  typedef struct packed {
    logic [63:0] coefficient;
    logic [1:0]  status;
  } coefficient_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  request_t     pending_requests[$];
  coefficient_t awaited_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  binomial_coefficient_unit_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // C(n,k) with the numerator limited to RESULT_WIDTH bits; an overflowing
  // numerator gives zero rather than a wrapped value.
  function automatic coefficient_t binomial_of(logic [bcu_pkg::COUNT_W-1:0] total,
                                               logic [bcu_pkg::COUNT_W-1:0] chosen);
    coefficient_t r;
    logic [63:0]  limit;
    logic [63:0]  num;
    logic [63:0]  den;
    int           width;
    int           n;
    int           k;
    int           m;
    r.coefficient = '0;
    r.status = bcu_pkg::STATUS_OK;
    width = bcu_pkg::RESULT_WIDTH;
    if (width < 1) width = 1;
    if (width > 64) width = 64;
    limit = {64{1'b1}} >> (64 - width);
    n = total;
    k = chosen;
    if (k > n) begin
      r.status = bcu_pkg::STATUS_RANGE;
      return r;
    end
    m = (k < n - k) ? k : n - k;
    num = 64'd1;
    den = 64'd1;
    for (int i = n - m + 1; i <= n; i++) begin
      if (num > limit / 64'(i)) begin
        r.status = bcu_pkg::STATUS_OVERFLOW;
        return r;
      end
      num = num * 64'(i);
    end
    for (int i = 2; i <= m; i++) den = den * 64'(i);
    r.coefficient = num / den;
    return r;
  endfunction

  function automatic request_t make_request(int n, int k);
    request_t r;
    r.pad = '0;
    r.total = n[bcu_pkg::COUNT_W-1:0];
    r.chosen = k[bcu_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Mostly valid requests, many with small m so that many results fit; the
  // rest are wide random pairs and k greater than n.
  function automatic request_t draw_request();
    int kind;
    int n;
    int k;
    int m;
    kind = $urandom_range(0, 9);
    n = $urandom_range(0, 127);
    case (kind)
      0: begin
        k = $urandom_range(0, 127);
      end
      1: begin
        if (n == 127) n = $urandom_range(0, 126);
        k = $urandom_range(n + 1, 127);
      end
      2, 3, 4, 5: begin
        m = $urandom_range(0, 10);
        if (m > n) m = n;
        k = $urandom_range(0, 1) ? m : n - m;
      end
      default: begin
        k = $urandom_range(0, n);
      end
    endcase
    return make_request(n, k);
  endfunction

  // Driver: when the slot is free, offers the next pending word or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready)
        awaited_results.push_back(
          binomial_of(in_tdata[bcu_pkg::COUNT_W-1:0],
                      in_tdata[2*bcu_pkg::COUNT_W-1:bcu_pkg::COUNT_W]));
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_requests.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word and drives the receiver's ready.
  always @(posedge clk) begin
    coefficient_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result coefficient=%0d status=%0d",
                   $time, out_tdata, out_tuser);
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata !== want.coefficient) begin
            errors++;
            $display("%0t: coefficient expected %0d actual %0d",
                     $time, want.coefficient, out_tdata);
          end
          if (out_tuser !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_tuser);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        stall_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, range errors, empty products and overflow edges.
    pending_requests.push_back(make_request(0, 0));
    pending_requests.push_back(make_request(127, 0));
    pending_requests.push_back(make_request(127, 127));
    pending_requests.push_back(make_request(0, 127));
    pending_requests.push_back(make_request(0, 1));
    pending_requests.push_back(make_request(126, 127));
    pending_requests.push_back(make_request(1, 1));
    pending_requests.push_back(make_request(127, 1));
    pending_requests.push_back(make_request(127, 126));
    pending_requests.push_back(make_request(127, 63));
    pending_requests.push_back(make_request(127, 64));
    pending_requests.push_back(make_request(85, 42));
    pending_requests.push_back(make_request(10, 5));
    pending_requests.push_back(make_request(20, 10));
    pending_requests.push_back(make_request(33, 16));
    pending_requests.push_back(make_request(34, 17));
    pending_requests.push_back(make_request(40, 8));
    pending_requests.push_back(make_request(64, 32));
    pending_requests.push_back(make_request(100, 9));
    pending_requests.push_back(make_request(127, 9));
    pending_requests.push_back(make_request(127, 10));
    pending_requests.push_back(make_request(85, 85));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          send_idle_pct = 7;
          recv_idle_pct = 77;
        end
        2: begin
          send_idle_pct = 77;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase != 0) begin
        for (int j = 0; j < PHASE_WORDS; j++) pending_requests.push_back(draw_request());
        // The receiver stops for a long stretch so that the block backs up.
        if (phase != 2) hold_requests++;
      end
      // The sender pauses here until every result of the phase is in.
      while (pending_requests.size() != 0 || in_tvalid || awaited_results.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== binomial_coefficient_unit_top.f =====
rtl/bcu_pkg.sv
rtl/bcu_div.sv
rtl/binomial_coefficient_unit_top.sv
tb/sv/binomial_coefficient_unit_top_test.sv
